// ===== src/gha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants, command and status codes, and control types for the
// generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    // Default table geometry.
    localparam int SLOT_COUNT_DEF = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int DATA_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Command codes carried in the cmd field.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    // Write strobes from the engine to the slot memories.
    typedef struct packed {
        logic meta_we;
        logic data_we;
    } mem_ctl_t;

endpackage : gha_pkg
`default_nettype wire

// ===== src/gha_slot_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_slot_mem
// Per-slot storage: a metadata memory holding the live bit, generation and
// free-list link, and a payload memory. Both have one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module gha_slot_mem #(
    parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
    parameter int DATA_BITS  = gha_pkg::DATA_BITS_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT),
    parameter int SLOT_W     = $clog2(SLOT_COUNT + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_idx,
    output logic                      rd_live,
    output logic [GEN_BITS-1:0]       rd_gen,
    output logic [SLOT_W-1:0]         rd_link,
    output logic [DATA_BITS-1:0]      rd_data,
    input  wire gha_pkg::mem_ctl_t    wr_ctl,
    input  wire logic [IDX_W-1:0]     wr_idx,
    input  wire logic                 wr_live,
    input  wire logic [GEN_BITS-1:0]  wr_gen,
    input  wire logic [SLOT_W-1:0]    wr_link,
    input  wire logic [DATA_BITS-1:0] wr_data
);
    import gha_pkg::*;

    localparam int META_W = 1 + GEN_BITS + SLOT_W;

    logic [META_W-1:0]    meta_mem [SLOT_COUNT];
    logic [DATA_BITS-1:0] data_mem [SLOT_COUNT];
    logic [META_W-1:0]    meta_q_reg;
    logic [DATA_BITS-1:0] data_q_reg;

    // Metadata memory: synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_ctl.meta_we)
        begin
            meta_mem[wr_idx] <= {wr_live, wr_gen, wr_link};
        end
        if (rd_en)
        begin
            meta_q_reg <= meta_mem[rd_idx];
        end
    end

    // Payload memory: synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_ctl.data_we)
        begin
            data_mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            data_q_reg <= data_mem[rd_idx];
        end
    end

    // Unpack the metadata word.
    assign rd_live = meta_q_reg[META_W-1];
    assign rd_gen  = meta_q_reg[GEN_BITS+SLOT_W-1:SLOT_W];
    assign rd_link = meta_q_reg[SLOT_W-1:0];
    assign rd_data = data_q_reg;

endmodule : gha_slot_mem
`default_nettype wire

// ===== src/gha_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_engine
// Command evaluation: owns the free-list head and the fill mark, picks the
// slot to read, checks handles against the read-back slot, and forms the
// write-back and the result.
// ----------------------------------------------------------------------------
module gha_engine #(
    parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
    parameter int DATA_BITS  = gha_pkg::DATA_BITS_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT),
    parameter int SLOT_W     = $clog2(SLOT_COUNT + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Incoming item, used to pick the read address at acceptance.
    input  wire logic                          start,
    input  wire logic [gha_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [SLOT_W-1:0]             in_slot,
    output logic [IDX_W-1:0]                   rd_idx,
    // Registered item, evaluated in the cycle after acceptance.
    input  wire logic                          eval,
    input  wire logic [gha_pkg::CMD_W-1:0]     cmd,
    input  wire logic [SLOT_W-1:0]             handle_slot,
    input  wire logic [GEN_BITS-1:0]           handle_generation,
    input  wire logic [DATA_BITS-1:0]          entry_data,
    // Read-back from the slot memories.
    input  wire logic                          rd_live,
    input  wire logic [GEN_BITS-1:0]           rd_gen,
    input  wire logic [SLOT_W-1:0]             rd_link,
    input  wire logic [DATA_BITS-1:0]          rd_data,
    // Write-back to the slot memories.
    output gha_pkg::mem_ctl_t                  wr_ctl,
    output logic [IDX_W-1:0]                   wr_idx,
    output logic                               wr_live,
    output logic [GEN_BITS-1:0]                wr_gen,
    output logic [SLOT_W-1:0]                  wr_link,
    output logic [DATA_BITS-1:0]               wr_data,
    // Result fields.
    output logic [gha_pkg::STATUS_W-1:0]       status,
    output logic [SLOT_W-1:0]                  out_slot,
    output logic [GEN_BITS-1:0]                out_generation,
    output logic [DATA_BITS-1:0]               out_data
);
    import gha_pkg::*;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(SLOT_COUNT);

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  idx_reg;

    logic              touched;
    logic              eff_live;
    logic [GEN_BITS-1:0] eff_gen;
    logic [SLOT_W-1:0] eff_link;
    logic              range_ok;
    logic              handle_ok;

    // Read address: the list head for allocate, the handle's slot otherwise.
    always_comb
    begin
        if (in_cmd == CMD_ALLOC)
        begin
            rd_idx = IDX_W'(head_reg - SLOT_W'(1));
        end
        else
        begin
            rd_idx = IDX_W'(in_slot - SLOT_W'(1));
        end
    end

    // Hold the slot index for the write-back.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg <= rd_idx;
        end
    end

    // Slots at or above the fill mark were never written and read as their
    // reset contents: dead, generation zero, linked to the following slot (the last slot to none).
    always_comb
    begin
        touched  = SLOT_W'(idx_reg) < fill_reg;
        eff_live = touched & rd_live;
        eff_gen  = touched ? rd_gen : '0;
        if (touched)
        begin
            eff_link = rd_link;
        end
        else if (idx_reg == LAST_IDX)
        begin
            eff_link = '0;
        end
        else
        begin
            eff_link = SLOT_W'(idx_reg) + SLOT_W'(2);
        end
    end

    // Handle check: slot in range, live, and generation matches.
    always_comb
    begin
        range_ok  = (handle_slot != '0) && (handle_slot <= SLOT_MAX);
        handle_ok = range_ok && eff_live && (eff_gen == handle_generation);
    end

    // Command evaluation and write-back.
    always_comb
    begin
        status         = STAT_INVALID;
        out_slot       = '0;
        out_generation = '0;
        out_data       = '0;
        wr_ctl         = '0;
        wr_idx         = idx_reg;
        wr_live        = 1'b0;
        wr_gen         = eff_gen;
        wr_link        = '0;
        wr_data        = entry_data;
        head_next      = head_reg;
        fill_next      = fill_reg;
        case (cmd)
            CMD_ALLOC:
            begin
                if (head_reg == '0)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    status         = STAT_OK;
                    out_slot       = head_reg;
                    out_generation = eff_gen;
                    wr_ctl.meta_we = eval;
                    wr_ctl.data_we = eval;
                    wr_live        = 1'b1;
                    head_next      = eff_link;
                    if (!touched)
                    begin
                        fill_next = fill_reg + SLOT_W'(1);
                    end
                end
            end
            CMD_FREE:
            begin
                if (handle_ok)
                begin
                    status         = STAT_OK;
                    wr_ctl.meta_we = eval;
                    wr_gen         = eff_gen + GEN_BITS'(1);
                    wr_link        = head_reg;
                    head_next      = handle_slot;
                end
            end
            CMD_CHECK:
            begin
                if (handle_ok)
                begin
                    status   = STAT_OK;
                    out_data = rd_data;
                end
            end
            default:
            begin
                status = STAT_INVALID;
            end
        endcase
    end

    // List head and fill mark.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= SLOT_W'(1);
            fill_reg <= '0;
        end
        else if (eval)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

endmodule : gha_engine
`default_nettype wire

// ===== src/generational_handle_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// Slot allocator handing out handles of slot number and generation.
//
// Commands arrive as beats on the s_axis channel; each produces exactly one
// result beat on the m_axis channel. Allocate pops a slot from a LIFO free
// list, stores the payload and returns the handle (or reports a full table).
// Free validates a handle, bumps the slot generation and pushes the slot
// back. Check validates a handle and returns the stored payload.
// The slot's entry is read from the slot memories in the accept cycle and
// written back in the following one; no new command is accepted before
// that write-back, and the result is loaded into the output register with
// it. A new command is accepted only while the output register is empty
// or being drained; a stalled receiver holds the result and the input side
// waits. Reset empties the output, places every slot on the free list in
// order and marks all slots dead with generation zero; no memory clearing
// pass is needed, so the first command is accepted right after reset.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core #(
    parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
    parameter int DATA_BITS  = gha_pkg::DATA_BITS_DEF,
    parameter int SLOT_W     = $clog2(SLOT_COUNT + 1),
    parameter int FIELD_W    = gha_pkg::CMD_W + SLOT_W + GEN_BITS + DATA_BITS,
    parameter int BUS_W      = ((FIELD_W + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: cmd, handle_slot, handle_generation, entry_data.
    input  wire logic [BUS_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // Fields from bit 0: status, out_slot, out_generation, out_data.
    output logic [BUS_W-1:0]      m_axis_tdata
);
    import gha_pkg::*;

    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int SLOT_LO = CMD_W;
    localparam int GEN_LO  = SLOT_LO + SLOT_W;
    localparam int DATA_LO = GEN_LO + GEN_BITS;

    state_t state_reg, state_next;

    logic                  accept;
    logic                  eval;

    logic [CMD_W-1:0]      in_cmd;
    logic [SLOT_W-1:0]     in_slot;

    logic [CMD_W-1:0]      cmd_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [GEN_BITS-1:0]   gen_reg;
    logic [DATA_BITS-1:0]  data_reg;

    logic [IDX_W-1:0]      rd_idx;
    logic                  rd_live;
    logic [GEN_BITS-1:0]   rd_gen;
    logic [SLOT_W-1:0]     rd_link;
    logic [DATA_BITS-1:0]  rd_data;

    mem_ctl_t              wr_ctl;
    logic [IDX_W-1:0]      wr_idx;
    logic                  wr_live;
    logic [GEN_BITS-1:0]   wr_gen;
    logic [SLOT_W-1:0]     wr_link;
    logic [DATA_BITS-1:0]  wr_data;

    logic [STATUS_W-1:0]   res_status;
    logic [SLOT_W-1:0]     res_slot;
    logic [GEN_BITS-1:0]   res_gen;
    logic [DATA_BITS-1:0]  res_data;

    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    out_word_reg;

    // Unpack the input beat.
    assign in_cmd  = s_axis_tdata[CMD_W-1:0];
    assign in_slot = s_axis_tdata[GEN_LO-1:SLOT_LO];

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        eval          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = !out_valid_reg || m_axis_tready;
            end
            S_EVAL:
            begin
                eval = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the accepted command.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_cmd;
            slot_reg <= in_slot;
            gen_reg  <= s_axis_tdata[DATA_LO-1:GEN_LO];
            data_reg <= s_axis_tdata[FIELD_W-1:DATA_LO];
        end
    end

    gha_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS),
        .DATA_BITS  (DATA_BITS),
        .IDX_W      (IDX_W),
        .SLOT_W     (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_idx  (rd_idx),
        .rd_live (rd_live),
        .rd_gen  (rd_gen),
        .rd_link (rd_link),
        .rd_data (rd_data),
        .wr_ctl  (wr_ctl),
        .wr_idx  (wr_idx),
        .wr_live (wr_live),
        .wr_gen  (wr_gen),
        .wr_link (wr_link),
        .wr_data (wr_data)
    );

    gha_engine #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS),
        .DATA_BITS  (DATA_BITS),
        .IDX_W      (IDX_W),
        .SLOT_W     (SLOT_W)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (accept),
        .in_cmd            (in_cmd),
        .in_slot           (in_slot),
        .rd_idx            (rd_idx),
        .eval              (eval),
        .cmd               (cmd_reg),
        .handle_slot       (slot_reg),
        .handle_generation (gen_reg),
        .entry_data        (data_reg),
        .rd_live           (rd_live),
        .rd_gen            (rd_gen),
        .rd_link           (rd_link),
        .rd_data           (rd_data),
        .wr_ctl            (wr_ctl),
        .wr_idx            (wr_idx),
        .wr_live           (wr_live),
        .wr_gen            (wr_gen),
        .wr_link           (wr_link),
        .wr_data           (wr_data),
        .status            (res_status),
        .out_slot          (res_slot),
        .out_generation    (res_gen),
        .out_data          (res_data)
    );

    // Output register: loaded after evaluation, emptied when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eval)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            out_word_reg <= {res_data, res_gen, res_slot, res_status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = BUS_W'(out_word_reg);

endmodule : generational_handle_allocator_core
`default_nettype wire

// ===== dv/generational_handle_allocator_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator_core_tb
// Self-checking testbench for the generational handle allocator.
//
// Command beats go in on s_axis and result beats come out on m_axis. A
// scoreboard keeps its own copy of the slot table, predicts one result per
// accepted command and compares every result beat field by field. The
// stimulus has a directed part for the corner cases, then a short
// allocate/free loop that reuses one slot and steps its generation, then
// random traffic that alternates between filling and draining the table.
// The sender pauses in random gaps and the receiver stalls on a pattern of
// its own.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core_tb;

    import gha_pkg::*;

    localparam int SLOTS      = SLOT_COUNT_DEF;
    localparam int SLOT_W     = 7;
    localparam int GEN_W      = GEN_BITS_DEF;
    localparam int DATA_W     = DATA_BITS_DEF;
    localparam int BUS_W      = 48;
    localparam int BEAT_W     = CMD_W + SLOT_W + GEN_W + DATA_W;
    localparam int RANDOM_CMDS = 1500;
    localparam int REUSE_ROUNDS = 200;
    localparam int MAX_REPORTS = 10;

    // The encoding the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Command beat, first field in the lowest bits.
    typedef struct packed {
        logic [DATA_W-1:0] entry_data;
        logic [GEN_W-1:0]  handle_generation;
        logic [SLOT_W-1:0] handle_slot;
        logic [CMD_W-1:0]  cmd;
    } cmd_beat_t;

    // Result beat, first field in the lowest bits.
    typedef struct packed {
        logic [DATA_W-1:0]   out_data;
        logic [GEN_W-1:0]    out_generation;
        logic [SLOT_W-1:0]   out_slot;
        logic [STATUS_W-1:0] status;
    } result_beat_t;

    typedef enum {
        BIAS_FILL,
        BIAS_MIXED,
        BIAS_DRAIN
    } bias_t;

    // ------------------------------------------------------------------------
    // Slot table shadow and result checker
    // ------------------------------------------------------------------------
    class handle_table_scoreboard;
        logic [SLOT_W-1:0] free_head;
        logic [SLOT_W-1:0] next_link [SLOTS];
        logic [GEN_W-1:0]  slot_gen [SLOTS];
        bit                slot_live [SLOTS];
        logic [DATA_W-1:0] slot_payload [SLOTS];
        result_beat_t      expected_q [$];
        int                mismatches;

        function new();
            free_head  = 1;
            mismatches = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                next_link[i]    = (i + 1 < SLOTS) ? SLOT_W'(i + 2) : '0;
                slot_gen[i]     = '0;
                slot_live[i]    = 1'b0;
                slot_payload[i] = '0;
            end
        endfunction

        // A handle is live when its slot is in range, allocated, and the
        // generation matches the one currently stored for the slot.
        function bit handle_live(logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen);
            if (slot == 0 || slot > SLOTS)
                return 1'b0;
            return slot_live[slot - 1] && slot_gen[slot - 1] == gen;
        endfunction

        // Applies an accepted command to the shadow table and queues its result.
        function void note_command(cmd_beat_t c);
            result_beat_t exp_r;
            int           idx;
            exp_r        = '0;
            exp_r.status = STAT_INVALID;
            idx          = int'(c.handle_slot) - 1;
            case (c.cmd)
                CMD_ALLOC:
                begin
                    if (free_head == 0)
                    begin
                        exp_r.status = STAT_FULL;
                    end
                    else
                    begin
                        idx                  = int'(free_head) - 1;
                        exp_r.status         = STAT_OK;
                        exp_r.out_slot       = free_head;
                        exp_r.out_generation = slot_gen[idx];
                        slot_live[idx]       = 1'b1;
                        slot_payload[idx]    = c.entry_data;
                        free_head            = next_link[idx];
                        next_link[idx]       = '0;
                    end
                end
                CMD_FREE:
                begin
                    if (handle_live(c.handle_slot, c.handle_generation))
                    begin
                        exp_r.status   = STAT_OK;
                        slot_gen[idx]  = slot_gen[idx] + 1'b1;
                        slot_live[idx] = 1'b0;
                        next_link[idx] = free_head;
                        free_head      = c.handle_slot;
                    end
                end
                CMD_CHECK:
                begin
                    if (handle_live(c.handle_slot, c.handle_generation))
                    begin
                        exp_r.status   = STAT_OK;
                        exp_r.out_data = slot_payload[idx];
                    end
                end
                default:
                begin
                end
            endcase
            expected_q.push_back(exp_r);
        endfunction

        // Compares one result beat with the oldest pending prediction.
        function void check_result(result_beat_t got);
            result_beat_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: status %0d slot %0d gen %h data %h",
                             got.status, got.out_slot, got.out_generation, got.out_data);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status || got.out_slot !== exp_r.out_slot ||
                got.out_generation !== exp_r.out_generation ||
                got.out_data !== exp_r.out_data)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result mismatch: expected status %0d slot %0d gen %h data %h,",
                              " got status %0d slot %0d gen %h data %h"},
                             exp_r.status, exp_r.out_slot, exp_r.out_generation,
                             exp_r.out_data, got.status, got.out_slot,
                             got.out_generation, got.out_data);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block instance
    // ------------------------------------------------------------------------
    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [BUS_W-1:0] s_tdata  = '0;
    logic             s_tready;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [BUS_W-1:0] m_tdata;

    handle_table_scoreboard sb = new();

    int burst_left   = 0;
    int rx_mode      = 0;
    int rx_phase_left = 0;
    int rx_run       = 0;
    bit rx_level     = 1'b0;

    always #10 clk = ~clk;

    generational_handle_allocator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Command driving
    // ------------------------------------------------------------------------
    function automatic cmd_beat_t make_cmd(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                                           logic [GEN_W-1:0] gen, logic [DATA_W-1:0] data);
        cmd_beat_t c;
        c.cmd               = cmd;
        c.handle_slot       = slot;
        c.handle_generation = gen;
        c.entry_data        = data;
        return c;
    endfunction

    // Presents one beat and holds it until the block takes it.
    task automatic send_command(cmd_beat_t c);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(BUS_W - BEAT_W){1'b0}}, c};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(c);
    endtask

    // Same as send_command, but opens a random gap between bursts.
    task automatic send_paced(cmd_beat_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_command(c);
    endtask

    // Picks the next random command from the current table contents. Most
    // commands are allocates or use live handles; the rest are stale, dead or plain noise.
    function automatic cmd_beat_t random_command(bias_t bias);
        cmd_beat_t         c;
        int                pick;
        int                w_alloc;
        int                w_free;
        int                w_check;
        int                w_stale;
        logic [SLOT_W-1:0] live_q [$];
        logic [SLOT_W-1:0] s;
        c.cmd               = CMD_ALLOC;
        c.handle_slot       = SLOT_W'($urandom_range(0, 127));
        c.handle_generation = GEN_W'($urandom);
        c.entry_data        = ($urandom_range(0, 9) == 0) ?
                              ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : DATA_W'($urandom);
        for (int i = 0; i < SLOTS; i++)
            if (sb.slot_live[i])
                live_q.push_back(SLOT_W'(i + 1));
        case (bias)
            BIAS_FILL:  begin w_alloc = 60; w_free = 10; w_check = 15; w_stale = 8;  end
            BIAS_DRAIN: begin w_alloc = 10; w_free = 55; w_check = 15; w_stale = 10; end
            default:    begin w_alloc = 30; w_free = 25; w_check = 25; w_stale = 10; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < w_alloc)
        begin
            // Allocate with whatever the handle fields hold.
        end
        else if (pick < w_alloc + w_free + w_check && live_q.size() > 0)
        begin
            s = live_q[$urandom_range(0, live_q.size() - 1)];
            c.cmd               = (pick < w_alloc + w_free) ? CMD_FREE : CMD_CHECK;
            c.handle_slot       = s;
            c.handle_generation = sb.slot_gen[s - 1];
        end
        else if (pick < w_alloc + w_free + w_check + w_stale)
        begin
            // A handle whose generation is one off, or one to a dead slot.
            s = SLOT_W'($urandom_range(1, SLOTS));
            c.cmd               = $urandom_range(0, 1) ? CMD_FREE : CMD_CHECK;
            c.handle_slot       = s;
            c.handle_generation = sb.slot_gen[s - 1] - GEN_W'($urandom_range(0, 1));
            if (sb.slot_live[s - 1] && c.handle_generation == sb.slot_gen[s - 1])
                c.handle_generation = c.handle_generation + 1'b1;
        end
        else
        begin
            c.cmd = CMD_W'($urandom_range(0, 3));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check each beat, stall on a pattern of its own
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[BEAT_W-1:0]);
        if (rx_phase_left == 0)
        begin
            rx_mode       = $urandom_range(0, 2);
            rx_phase_left = $urandom_range(16, 256);
        end
        rx_phase_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_level = !rx_level;
                    rx_run   = $urandom_range(1, 12);
                end
                rx_run--;
                m_tready <= rx_level;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0]  g;
        bias_t             bias;
        int                phase_len;
        int                sent;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners: null and out-of-range handles, the unused
        // command, payload extremes, stale and dead handles, LIFO reuse.
        send_paced(make_cmd(CMD_CHECK,  7'd0,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_FREE,   7'd0,   16'h0000, 16'hFFFF));
        send_paced(make_cmd(CMD_CHECK,  7'd127, 16'hFFFF, 16'hFFFF));
        send_paced(make_cmd(CMD_FREE,   7'd65,  16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_UNUSED, 7'd127, 16'hFFFF, 16'hFFFF));
        send_paced(make_cmd(CMD_ALLOC,  7'd127, 16'hFFFF, 16'h0000));
        send_paced(make_cmd(CMD_ALLOC,  7'd0,   16'h0000, 16'hFFFF));
        send_paced(make_cmd(CMD_CHECK,  7'd1,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_CHECK,  7'd2,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_CHECK,  7'd2,   16'h0001, 16'h0000));
        send_paced(make_cmd(CMD_CHECK,  7'd3,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_FREE,   7'd1,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_FREE,   7'd1,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_CHECK,  7'd1,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_ALLOC,  7'd0,   16'h0000, 16'hA5A5));
        send_paced(make_cmd(CMD_CHECK,  7'd1,   16'h0001, 16'h0000));
        send_paced(make_cmd(CMD_FREE,   7'd1,   16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_CHECK,  7'd64,  16'h0000, 16'h0000));
        send_paced(make_cmd(CMD_FREE,   7'd64,  16'hFFFF, 16'h0000));

        // Cycle one slot through allocate and free so that its generation
        // climbs by one with every reuse.
        for (int n = 0; n < REUSE_ROUNDS; n++)
        begin
            s = sb.free_head;
            g = sb.slot_gen[s - 1];
            send_command(make_cmd(CMD_ALLOC, 7'd0, 16'h0000, DATA_W'(n)));
            send_command(make_cmd(CMD_FREE, s, g, 16'h0000));
        end
        send_paced(make_cmd(CMD_ALLOC, 7'd0, 16'h0000, 16'h5A5A));
        send_paced(make_cmd(CMD_CHECK, s, g, 16'h0000));
        send_paced(make_cmd(CMD_CHECK, s, g - 1'b1, 16'h0000));

        // Random traffic in phases; the first one is biased towards filling the table.
        sent = 0;
        bias = BIAS_FILL;
        while (sent < RANDOM_CMDS)
        begin
            phase_len = (sent == 0) ? 200 : $urandom_range(60, 200);
            for (int k = 0; k < phase_len; k++)
                send_paced(random_command(bias));
            sent += phase_len;
            bias = bias_t'($urandom_range(0, 2));
        end

        // Drain: wait for every pending result, then report the verdict.
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("generational_handle_allocator_core_tb: PASS");
        else
            $display("generational_handle_allocator_core_tb: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #500_000_000;
        $display("generational_handle_allocator_core_tb: FAIL");
        $finish;
    end

endmodule : generational_handle_allocator_core_tb
`default_nettype wire
